@@ rtl/core/pasm_pkg.sv @@
`default_nettype none

package pasm_pkg;

    // Envelope stage codes as stored per voice.
    typedef enum logic [2:0] {
        VS_IDLE    = 3'd0,
        VS_ATTACK  = 3'd1,
        VS_DECAY   = 3'd2,
        VS_SUSTAIN = 3'd3,
        VS_RELEASE = 3'd4
    } voice_stage_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ATTACK_RATE    = 3'd0,
        CFG_DECAY_RATE     = 3'd1,
        CFG_RELEASE_RATE   = 3'd2,
        CFG_SUSTAIN_LEVEL  = 3'd3,
        CFG_DONE_THRESHOLD = 3'd4,
        CFG_VOICE_GAIN     = 3'd5,
        CFG_TRANSPOSE      = 3'd6
    } cfg_index_t;

    // Envelope part of one voice's state.
    typedef struct packed {
        voice_stage_t stage;
        logic [15:0]  amp;
    } voice_env_t;

    localparam logic [15:0] FULL_AMP     = 16'd32768;
    localparam logic [14:0] STAB_Q15     = 15'd22938;
    localparam logic [6:0]  OUT_SCALE    = 7'd125;
    localparam int          KEY_BITS     = 13;
    localparam int          SUM_BITS     = 56;

endpackage

`default_nettype wire

@@ rtl/core/pasm_cell.sv @@
`default_nettype none

// One link of the voice ring: holds a voice's state and passes it on when shifted.
module pasm_cell
    import pasm_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter logic [PHASE_BITS-1:0] RESET_STEP = '0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  shift,
    input  wire voice_env_t            env_in,
    input  wire logic [PHASE_BITS-1:0] phase_in,
    input  wire logic [PHASE_BITS-1:0] step_in,
    output voice_env_t                 env_out,
    output logic [PHASE_BITS-1:0]      phase_out,
    output logic [PHASE_BITS-1:0]      step_out
);

    voice_env_t            env_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg   <= '{stage: VS_IDLE, amp: 16'd0};
            phase_reg <= '0;
            step_reg  <= RESET_STEP;
        end
        else if (shift)
        begin
            env_reg   <= env_in;
            phase_reg <= phase_in;
            step_reg  <= step_in;
        end
    end

    assign env_out   = env_reg;
    assign phase_out = phase_reg;
    assign step_out  = step_reg;

endmodule

`default_nettype wire

@@ rtl/core/polyphonic_adsr_sine_mixer_core.sv @@
`default_nettype none

// Polyphonic ADSR sine mixer. Each input beat is one sample tick carrying the key-held
// mask (bit k = key of voice k); each tick yields one output beat with the mixed,
// clamped 16-bit sample. Voice state (stage, amplitude, phase, tuning step) lives in a
// ring of cells that rotates past one shared envelope/oscillator datapath. Each voice
// goes through a five-step sequence through the shared multipliers (ENV, AMP, GAIN,
// STAB, ACC); after the last voice, S_FIN loads the output register once it is free
// and the block returns to idle, and only then is the next tick accepted. A new tick
// is accepted while the previous result still waits in the output register.
// Configuration must be written by the user through cfg_we/cfg_addr/cfg_wdata only
// while the block is idle; the block itself does not enforce this. Indexes beyond
// the register list are ignored.
module polyphonic_adsr_sine_mixer_core
    import pasm_pkg::*;
#(
    parameter int VOICES             = 13,
    parameter int SINE_TABLE_ENTRIES = 1024,
    parameter int PHASE_BITS         = 32,
    parameter int SAMPLE_RATE_HZ     = 48000
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [12:0] key_mask, [15:13] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] sample
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int IW = $clog2(SINE_TABLE_ENTRIES);
    localparam int CW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    typedef logic signed [15:0] sine_rom_t [SINE_TABLE_ENTRIES];

    // Tuning step of one voice, worked out at elaboration.
    function automatic logic [PHASE_BITS-1:0] calc_step(input int v);
        logic [63:0] f;
        logic [63:0] den;
        logic [63:0] q;
        begin
            case (v % 12)
                0: f = 64'd1635;
                1: f = 64'd1732;
                2: f = 64'd1835;
                3: f = 64'd1945;
                4: f = 64'd2060;
                5: f = 64'd2183;
                6: f = 64'd2312;
                7: f = 64'd2450;
                8: f = 64'd2596;
                9: f = 64'd2750;
                10: f = 64'd2914;
                default: f = 64'd3087;
            endcase
            f   = f << (v / 12);
            den = 64'(100 * SAMPLE_RATE_HZ);
            q   = ((f << PHASE_BITS) + (den >> 1)) / (100 * SAMPLE_RATE_HZ);
            return q[PHASE_BITS-1:0];
        end
    endfunction

    // Sine table entry from a seven-term Taylor series on a Q30 angle.
    function automatic logic signed [15:0] sine_entry(input int i);
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        logic        neg;
        begin
            th  = (TWO_PI_Q30 * 64'(i)) / SINE_TABLE_ENTRIES;
            neg = 1'b0;
            if (th >= PI_Q30)
            begin
                th  = th - PI_Q30;
                neg = 1'b1;
            end
            if (th > HALF_PI_Q30)
                th = PI_Q30 - th;
            x2   = (th * th) >> 30;
            term = th;
            sum  = longint'(th);
            term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
            if (sum < 0)
                sum = 0;
            v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
            if (v > 32767)
                v = 32767;
            return neg ? 16'(-v) : 16'(v);
        end
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t r;
        begin
            for (int k = 0; k < SINE_TABLE_ENTRIES; k++)
                r[k] = sine_entry(k);
            return r;
        end
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    // Sequencer states.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ENV  = 7'b0000010,
        S_AMP  = 7'b0000100,
        S_GAIN = 7'b0001000,
        S_STAB = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_FIN  = 7'b1000000
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0]       attack_rate_reg, decay_rate_reg, release_rate_reg;
    logic [15:0]       sustain_level_reg, done_threshold_reg, voice_gain_reg;
    logic signed [4:0] transpose_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_rate_reg    <= 16'd64;
            decay_rate_reg     <= 16'd16;
            release_rate_reg   <= 16'd16;
            sustain_level_reg  <= 16'd22938;
            done_threshold_reg <= 16'd33;
            voice_gain_reg     <= 16'd6554;
            transpose_reg      <= 5'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ATTACK_RATE:    attack_rate_reg    <= cfg_wdata;
                CFG_DECAY_RATE:     decay_rate_reg     <= cfg_wdata;
                CFG_RELEASE_RATE:   release_rate_reg   <= cfg_wdata;
                CFG_SUSTAIN_LEVEL:  sustain_level_reg  <= cfg_wdata;
                CFG_DONE_THRESHOLD: done_threshold_reg <= cfg_wdata;
                CFG_VOICE_GAIN:     voice_gain_reg     <= cfg_wdata;
                CFG_TRANSPOSE:      transpose_reg      <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Voice ring. Cell 0 is the head that the datapath reads; the written-back voice
    // enters at the tail, so after VOICES shifts the ring is back in voice order.
    voice_env_t            env_c   [VOICES];
    logic [PHASE_BITS-1:0] phase_c [VOICES];
    logic [PHASE_BITS-1:0] step_c  [VOICES];
    voice_env_t            wb_env;
    logic [PHASE_BITS-1:0] wb_phase;
    logic                  ring_shift;

    for (genvar g = 0; g < VOICES; g++)
    begin : g_cell
        voice_env_t            env_i;
        logic [PHASE_BITS-1:0] phase_i;
        logic [PHASE_BITS-1:0] step_i;
        if (g == VOICES - 1)
        begin : g_tail
            assign env_i   = wb_env;
            assign phase_i = wb_phase;
            assign step_i  = step_c[0];
        end
        else
        begin : g_link
            assign env_i   = env_c[g+1];
            assign phase_i = phase_c[g+1];
            assign step_i  = step_c[g+1];
        end
        pasm_cell #(
            .PHASE_BITS (PHASE_BITS),
            .RESET_STEP (calc_step(g))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (ring_shift),
            .env_in    (env_i),
            .phase_in  (phase_i),
            .step_in   (step_i),
            .env_out   (env_c[g]),
            .phase_out (phase_c[g]),
            .step_out  (step_c[g])
        );
    end

    // Per-tick control.
    logic [KEY_BITS-1:0] keys_reg;
    logic [CW-1:0]       cnt_reg;
    logic                out_free;

    assign out_free   = !m_tvalid || m_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign ring_shift = (state_reg == S_AMP);

    // Envelope step, phase step and sine table index on the head voice.
    logic               held;
    voice_stage_t       st1, st2;
    logic [15:0]        sus, tgt, rate, amp_h, amp0;
    logic signed [17:0] d_close, diff;
    logic [17:0]        d_abs;
    logic [15:0]        mag;
    logic [PHASE_BITS-1:0] step_sh;
    logic [PHASE_BITS+IW-1:0] idx_prod;

    always_comb
    begin
        held    = (32'(cnt_reg) < 32'(KEY_BITS)) && keys_reg[4'(cnt_reg)];
        amp_h   = env_c[0].amp;
        sus     = (sustain_level_reg > FULL_AMP) ? FULL_AMP : sustain_level_reg;
        st1     = env_c[0].stage;
        if (held && st1 == VS_IDLE)
            st1 = VS_ATTACK;
        else if (!held && st1 != VS_IDLE && st1 != VS_RELEASE)
            st1 = VS_RELEASE;
        st2     = st1;
        amp0    = amp_h;
        tgt     = 16'd0;
        rate    = 16'd0;
        d_close = 18'sd0;
        case (st1)
            VS_ATTACK:
            begin
                tgt     = FULL_AMP;
                rate    = attack_rate_reg;
                d_close = $signed({2'b00, FULL_AMP}) - $signed({2'b00, amp_h});
            end
            VS_DECAY:
            begin
                tgt     = sus;
                rate    = decay_rate_reg;
                d_close = $signed({2'b00, sus}) - $signed({2'b00, amp_h});
            end
            VS_SUSTAIN:
                tgt = sus;
            VS_RELEASE:
                rate = release_rate_reg;
            default: ;
        endcase
        d_abs = d_close[17] ? 18'(-d_close) : 18'(d_close);
        if ((st1 == VS_ATTACK || st1 == VS_DECAY) && d_abs < {2'b00, done_threshold_reg})
            st2 = (st1 == VS_ATTACK) ? VS_DECAY : VS_SUSTAIN;
        if (st1 == VS_RELEASE && amp_h < done_threshold_reg)
        begin
            st2  = VS_IDLE;
            amp0 = 16'd0;
        end
        diff = $signed({2'b00, tgt}) - $signed({2'b00, amp0});
        mag  = diff[17] ? 16'(-diff) : 16'(diff);
        if (transpose_reg[4])
            step_sh = step_c[0] >> 5'(-transpose_reg);
        else
            step_sh = step_c[0] << transpose_reg[3:0];
        idx_prod = (PHASE_BITS+IW)'(phase_c[0]) * (PHASE_BITS+IW)'(SINE_TABLE_ENTRIES);
    end

    // Datapath registers.
    voice_stage_t          st2_reg;
    logic [15:0]           amp0_reg;
    logic                  neg_reg;
    logic                  active_reg;
    logic [31:0]           prod_reg;
    logic [PHASE_BITS-1:0] phase_nx_reg;
    logic signed [15:0]    sine_reg;
    logic signed [32:0]    p1_reg;
    logic signed [49:0]    t_reg;
    logic signed [42:0]    hi_reg;
    logic [37:0]           lo_reg;
    logic signed [SUM_BITS-1:0] sum_reg;

    logic [16:0]           inc;
    logic [15:0]           amp_new;
    logic signed [65:0]    scaled;
    logic signed [SUM_BITS-1:0] term;
    logic signed [SUM_BITS-1:0] sum_cl;
    logic signed [SUM_BITS-1:0] sum_sc;
    logic signed [SUM_BITS-1:0] lim;

    always_comb
    begin
        inc      = 17'((33'(prod_reg) + 33'd65535) >> 16);
        amp_new  = neg_reg ? (amp0_reg - inc[15:0]) : (amp0_reg + inc[15:0]);
        wb_env   = '{stage: st2_reg, amp: amp_new};
        wb_phase = phase_nx_reg;
        scaled   = ((66'(hi_reg)) <<< 23) + $signed({28'd0, lo_reg});
        if (transpose_reg > 5'sd4)
            term = SUM_BITS'(scaled >>> 15);
        else
            term = SUM_BITS'(t_reg);
        lim      = SUM_BITS'(1) <<< 45;
        if (sum_reg > lim)
            sum_cl = lim;
        else if (sum_reg < -lim)
            sum_cl = -lim;
        else
            sum_cl = sum_reg;
        sum_sc   = sum_cl * $signed({1'b0, OUT_SCALE});
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_ENV:
            begin
                st2_reg      <= st2;
                amp0_reg     <= amp0;
                neg_reg      <= diff[17];
                active_reg   <= (st2 != VS_IDLE);
                prod_reg     <= mag * rate;
                phase_nx_reg <= (st2 != VS_IDLE) ? (phase_c[0] + step_sh) : phase_c[0];
                sine_reg     <= SINE_ROM[idx_prod[PHASE_BITS+IW-1:PHASE_BITS]];
            end
            S_AMP:
                p1_reg <= sine_reg * $signed({1'b0, amp_new});
            S_GAIN:
                t_reg <= p1_reg * $signed({1'b0, voice_gain_reg});
            S_STAB:
            begin
                // The upper part keeps the sign of the term; the lower part is unsigned.
                hi_reg <= $signed(t_reg[49:23]) * $signed({1'b0, STAB_Q15});
                lo_reg <= t_reg[22:0] * STAB_Q15;
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_ENV;
            S_ENV:  state_next = S_AMP;
            S_AMP:  state_next = S_GAIN;
            S_GAIN: state_next = S_STAB;
            S_STAB: state_next = S_ACC;
            S_ACC:  state_next = (32'(cnt_reg) == VOICES - 1) ? S_FIN : S_ENV;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            keys_reg  <= '0;
            sum_reg   <= '0;
            m_tvalid  <= 1'b0;
            m_tdata   <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            // A finished tick refills the output register once it is empty, or in the same cycle
            // that the waiting beat leaves it.
            if (state_reg == S_FIN && out_free)
            begin
                m_tvalid <= 1'b1;
                m_tdata  <= 16'(sum_sc >>> 37);
            end
            else if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                    begin
                        keys_reg <= s_tdata[KEY_BITS-1:0];
                        cnt_reg  <= '0;
                        sum_reg  <= '0;
                    end
                S_ACC:
                begin
                    if (active_reg)
                        sum_reg <= sum_reg + term;
                    cnt_reg <= cnt_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end

    // The input side only opens when no tick is in progress.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("input ready while a tick is in progress");

    // The voice counter never points past the last voice while voices are processed.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_FIN) |-> (32'(cnt_reg) < VOICES))
        else $error("voice counter out of range");

    // A finished tick with a free output slot always presents a result next cycle.
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> m_tvalid)
        else $error("result lost at end of tick");

    // Envelope amplitude never rises above full scale.
    a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_c[0].amp <= FULL_AMP)
        else $error("amplitude above full scale");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

import pasm_pkg::*;

// Predicts the mixed sample for every accepted tick and holds the samples
// that are still owed by the block.
class adsr_mix_scoreboard;
    int unsigned          attack_rate, decay_rate, release_rate;
    int unsigned          sustain_level, done_threshold, voice_gain;
    int                   transpose;
    voice_stage_t         stage[13];
    int                   amp[13];
    longint unsigned      phase[13];
    longint unsigned      base_step[13];
    int                   sine_tab[1024];
    logic [15:0]          owed_samples[$];
    int                   mismatches;

    function new();
        int unsigned     centihz[12] = '{1635, 1732, 1835, 1945, 2060, 2183,
                                         2312, 2450, 2596, 2750, 2914, 3087};
        longint unsigned th, x2, trm, f;
        longint          s, v;
        bit              neg;
        attack_rate    = 64;
        decay_rate     = 16;
        release_rate   = 16;
        sustain_level  = 22938;
        done_threshold = 33;
        voice_gain     = 6554;
        transpose      = 0;
        mismatches     = 0;
        for (int i = 0; i < 13; i++)
        begin
            stage[i] = VS_IDLE;
            amp[i]   = 0;
            phase[i] = 0;
            f = longint'(centihz[i % 12]) << (i / 12);
            base_step[i] = ((f << 32) + 64'd2400000) / 64'd4800000;
        end
        // Quarter-wave folded Taylor series in Q30, rounded to Q1.15.
        for (int i = 0; i < 1024; i++)
        begin
            th  = (64'd6746518852 * i) / 1024;
            neg = 0;
            if (th >= 64'd3373259426)
            begin
                th  = th - 64'd3373259426;
                neg = 1;
            end
            if (th > 64'd1686629713)
                th = 64'd3373259426 - th;
            x2  = (th * th) >> 30;
            trm = th;
            s   = th;
            for (int n = 1; n <= 6; n++)
            begin
                trm = ((trm * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    s = s - longint'(trm);
                else
                    s = s + longint'(trm);
            end
            if (s < 0)
                s = 0;
            v = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
            if (v > 32767)
                v = 32767;
            sine_tab[i] = neg ? -int'(v) : int'(v);
        end
    endfunction

    function void write_reg(cfg_index_t idx, logic [15:0] value);
        case (idx)
            CFG_ATTACK_RATE:    attack_rate    = value;
            CFG_DECAY_RATE:     decay_rate     = value;
            CFG_RELEASE_RATE:   release_rate   = value;
            CFG_SUSTAIN_LEVEL:  sustain_level  = value;
            CFG_DONE_THRESHOLD: done_threshold = value;
            CFG_VOICE_GAIN:     voice_gain     = value;
            CFG_TRANSPOSE:      transpose      = $signed(value[4:0]);
            default: ;
        endcase
    endfunction

    // Advances every voice by one tick and queues the resulting sample.
    function void note_tick(logic [12:0] keys);
        voice_stage_t    st;
        int              a, tgt, d, sus, thr;
        longint unsigned rate, mag, step;
        longint          trm, total, smp;
        total = 0;
        sus = (sustain_level > 32768) ? 32768 : int'(sustain_level);
        thr = int'(done_threshold);
        for (int k = 0; k < 13; k++)
        begin
            st   = stage[k];
            a    = amp[k];
            tgt  = 0;
            rate = 0;
            if (keys[k] && st == VS_IDLE)
                st = VS_ATTACK;
            else if (!keys[k] && st != VS_IDLE && st != VS_RELEASE)
                st = VS_RELEASE;
            // The closeness test looks at the amplitude before this tick's move.
            case (st)
                VS_ATTACK:
                begin
                    tgt  = 32768;
                    rate = attack_rate;
                    d    = 32768 - a;
                    if ((d < 0 ? -d : d) < thr)
                        st = VS_DECAY;
                end
                VS_DECAY:
                begin
                    tgt  = sus;
                    rate = decay_rate;
                    d    = sus - a;
                    if ((d < 0 ? -d : d) < thr)
                        st = VS_SUSTAIN;
                end
                VS_SUSTAIN:
                    tgt = sus;
                VS_RELEASE:
                begin
                    rate = release_rate;
                    if (a < thr)
                    begin
                        st = VS_IDLE;
                        a  = 0;
                    end
                end
                default: ;
            endcase
            d = tgt - a;
            if (d != 0 && rate != 0)
            begin
                mag = (d < 0) ? -d : d;
                mag = (mag * rate + 65535) >> 16;
                a   = (d < 0) ? a - int'(mag) : a + int'(mag);
            end
            stage[k] = st;
            amp[k]   = a;
            if (st != VS_IDLE)
            begin
                trm = longint'(sine_tab[phase[k][31:22]]) * longint'(a)
                      * longint'(voice_gain);
                if (transpose > 4)
                    trm = (trm * 22938) >>> 15;
                total = total + trm;
                if (transpose >= 0)
                    step = base_step[k] << transpose;
                else
                    step = base_step[k] >> (-transpose);
                phase[k] = (phase[k] + step) & 64'hFFFF_FFFF;
            end
        end
        if (total > (64'sd1 <<< 45))
            total = 64'sd1 <<< 45;
        if (total < -(64'sd1 <<< 45))
            total = -(64'sd1 <<< 45);
        smp = (total * 32000) >>> 45;
        if (smp > 32000)
            smp = 32000;
        if (smp < -32000)
            smp = -32000;
        owed_samples.push_back(smp[15:0]);
    endfunction

    function void check_sample(logic [15:0] got);
        logic [15:0] want;
        if (owed_samples.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected sample beat: %0d", $signed(got));
            return;
        end
        want = owed_samples.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("sample mismatch: expected %0d, got %0d",
                         $signed(want), $signed(got));
        end
    endfunction

    function int outstanding();
        return owed_samples.size();
    endfunction
endclass

module testbench;
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;

    adsr_mix_scoreboard mix_sb = new();

    // Sender burst bookkeeping, the current key mask of the random part and the watchdog counter.
    int          burst_left = 0;
    logic [12:0] held_keys  = '0;
    int          quiet_cycles = 0;

    always #2 clk = ~clk;

    polyphonic_adsr_sine_mixer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [12:0] key_mask, [15:13] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [15:0] sample
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // The receiver switches at random between stall habits: always ready, ready
    // half the time, rarely ready, or ready but for a regular stall. Checking uses
    // the values seen just before the edge, so it cannot race the block.
    int rx_mode = 0;
    int rx_count = 0;
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            mix_sb.check_sample(m_tdata);
        rx_count <= rx_count + 1;
        if (rx_count % 64 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rx_count % 5 != 0);
        endcase
    end

    // The watchdog counts cycles in which no beat moves on either side and
    // no register is written.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == 20000)
        begin
            $display("polyphonic_adsr_sine_mixer_core regression: fail");
            $finish;
        end
    end

    // Sends one tick beat. Between bursts of random length the sender idles
    // for a random number of cycles; the gap is taken before valid is raised
    // so valid is never lowered and raised in the same step.
    task automatic send_tick(input logic [12:0] keys);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, keys};
        do
            @(posedge clk);
        while (!s_tready);
        mix_sb.note_tick(keys);
    endtask

    // Holds the sender until every owed sample has come back, then lets the
    // voice pipeline drain before registers may change.
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (mix_sb.outstanding() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // One write beat, then the enable is lowered before any further write, so the
    // enable is never lowered and raised in the same step.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mix_sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    // Rates favor fast envelopes so voices reach every stage in a short run,
    // with an occasional zero or full-scale value.
    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 255));
            default: return 16'($urandom_range(1024, 65535));
        endcase
    endfunction

    // Key masks drift: each key toggles now and then, so most ticks form
    // press-hold-release sequences, with a fully random mask as noise.
    function automatic logic [12:0] next_keys();
        logic [12:0] flips;
        if ($urandom_range(0, 19) == 0)
            return 13'($urandom_range(0, 8191));
        flips = '0;
        for (int k = 0; k < 13; k++)
            flips[k] = ($urandom_range(0, 11) == 0);
        return held_keys ^ flips;
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under reset settings: silence, all keys, release of
        // all keys, single keys at both ends, alternating masks.
        send_tick(13'h0000);
        repeat (4) send_tick(13'h1FFF);
        repeat (3) send_tick(13'h0000);
        send_tick(13'h0001);
        send_tick(13'h1000);
        send_tick(13'h1555);
        send_tick(13'h0AAA);
        send_tick(13'h1FFF);
        send_tick(13'h0000);
        wait_idle();

        // Fast envelopes with a tiny threshold, so attack ends on closeness,
        // decay reaches sustain and release returns voices to idle.
        write_reg(CFG_ATTACK_RATE, 16'hFFFF);
        write_reg(CFG_DECAY_RATE, 16'h8000);
        write_reg(CFG_RELEASE_RATE, 16'h8000);
        write_reg(CFG_DONE_THRESHOLD, 16'd200);
        write_reg(CFG_TRANSPOSE, 16'd8);
        repeat (3) send_tick(13'h1FFF);
        repeat (2) send_tick(13'h1F0F);
        repeat (3) send_tick(13'h0000);
        wait_idle();

        // Random phases. The first three pin extremes: rates, levels and gain at
        // zero, then at full amplitude or full scale, then the lowest shift of the
        // 5-bit field with a sustain above full amplitude. Phase 7 adds the highest.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(CFG_ATTACK_RATE, 16'd0);
                write_reg(CFG_DECAY_RATE, 16'd0);
                write_reg(CFG_RELEASE_RATE, 16'd0);
                write_reg(CFG_SUSTAIN_LEVEL, 16'd0);
                write_reg(CFG_DONE_THRESHOLD, 16'd0);
                write_reg(CFG_VOICE_GAIN, 16'd0);
                write_reg(CFG_TRANSPOSE, 16'h001C);
            end
            else if (ph == 1)
            begin
                write_reg(CFG_ATTACK_RATE, 16'hFFFF);
                write_reg(CFG_DECAY_RATE, 16'hFFFF);
                write_reg(CFG_RELEASE_RATE, 16'hFFFF);
                write_reg(CFG_SUSTAIN_LEVEL, 16'd32768);
                write_reg(CFG_DONE_THRESHOLD, 16'd32768);
                write_reg(CFG_VOICE_GAIN, 16'hFFFF);
                write_reg(CFG_TRANSPOSE, 16'd8);
            end
            else if (ph == 2)
            begin
                write_reg(CFG_ATTACK_RATE, 16'd30000);
                write_reg(CFG_DECAY_RATE, 16'd9000);
                write_reg(CFG_SUSTAIN_LEVEL, 16'hFFFF);
                write_reg(CFG_DONE_THRESHOLD, 16'd100);
                write_reg(CFG_TRANSPOSE, 16'h0010);
            end
            else
            begin
                write_reg(CFG_ATTACK_RATE, pick_rate());
                write_reg(CFG_DECAY_RATE, pick_rate());
                write_reg(CFG_RELEASE_RATE, pick_rate());
                write_reg(CFG_SUSTAIN_LEVEL, ($urandom_range(0, 5) == 0)
                          ? 16'($urandom_range(32769, 65535))
                          : 16'($urandom_range(0, 32768)));
                write_reg(CFG_DONE_THRESHOLD, ($urandom_range(0, 5) == 0)
                          ? 16'($urandom_range(0, 65535))
                          : 16'($urandom_range(0, 600)));
                write_reg(CFG_VOICE_GAIN, 16'($urandom_range(0, 65535)));
                write_reg(CFG_TRANSPOSE, ($urandom_range(0, 7) == 0)
                          ? {11'($urandom_range(0, 2047)), 5'($urandom_range(0, 31))}
                          : 16'(5'($urandom_range(0, 12) - 4)));
            end
            if (ph == 7)
                write_reg(CFG_TRANSPOSE, 16'h000F);
            for (int n = 0; n < 110; n++)
            begin
                held_keys = next_keys();
                send_tick(held_keys);
            end
            wait_idle();
        end

        if (mix_sb.mismatches == 0 && mix_sb.outstanding() == 0)
            $display("polyphonic_adsr_sine_mixer_core regression: pass");
        else
            $display("polyphonic_adsr_sine_mixer_core regression: fail");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/pasm_pkg.sv
rtl/core/pasm_cell.sv
rtl/core/polyphonic_adsr_sine_mixer_core.sv
sim/testbench.sv
